FILE: rtl/line_sum_rank_sort_assert.svh
// assertion macros used by line_sum_rank_sort
`ifndef LINE_SUM_RANK_SORT_ASSERT_SVH
`define LINE_SUM_RANK_SORT_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define LSRS_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// when the cause holds, the effect must hold in the next cycle
`define LSRS_ASSERT_NEXT(lbl, cause, effect, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

FILE: rtl/lsrs_pkg.sv
// ----------------------------------------------------------------------------
// lsrs_pkg
// shared constants and types for the line sum rank sort block
// ----------------------------------------------------------------------------
package lsrs_pkg;
    localparam int LINES        = 64;
    localparam int RANKED_CHECK = 7;
    localparam int IDX_W        = 6;
    localparam int SUM_W        = 32;
    localparam int SMP_W        = 16;
    localparam int FND_W        = 3;
    localparam int CHECKED      = (RANKED_CHECK < LINES) ? RANKED_CHECK : LINES;
    localparam int PRE_PASSES   = (CHECKED < 2) ? 2 : CHECKED;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [IDX_W-1:0]        idx;
        logic                    picked;
    } t_cell;
endpackage

FILE: rtl/lsrs_cell.sv
// ----------------------------------------------------------------------------
// lsrs_cell
// one ring cell: holds one line's sum, index and picked flag
// ----------------------------------------------------------------------------
module lsrs_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  logic           i_load,
    input  logic [5:0]     i_load_idx,
    input  lsrs_pkg::t_cell i_prev,
    output lsrs_pkg::t_cell o_data
);
    import lsrs_pkg::*;

    t_cell r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.sum    <= '0;
            r_data.idx    <= i_load_idx;
            r_data.picked <= 1'b0;
        end else if (i_shift) begin
            r_data <= i_prev;
        end
    end

    assign o_data = r_data;
endmodule

FILE: rtl/line_sum_rank_sort.sv
// ----------------------------------------------------------------------------
// line_sum_rank_sort
// per-line saturating accumulation, then descending rank by selection sort
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  s         in   i_s_tvalid/o_s_tready  tdata: sample, tlast: last_sample
//  m         out  o_m_tvalid/i_m_tready  tdata: line_index, top_gap, found_count
//                                        tlast: rank_last
//  cfg       in   i_cfg_we               i_cfg_wdata: hit_threshold
//
// samples are taken one per cycle; each one rotates the ring of LINES cells
// after the last sample the ring rotates through PRE_PASSES scans (gap, found
// count), then LINES scans, one result per scan
// a result waits in the output register until taken; the ring holds meanwhile
// reset (synchronous, active low) clears control and reloads the ring
// no sample is taken between the last sample and the final result
module line_sum_rank_sort (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] sample
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // [5:0] line_index, [37:6] top_gap, [40:38] found_count
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import lsrs_pkg::*;

    localparam logic [1:0] S_ACC = 2'd0;
    localparam logic [1:0] S_PRE = 2'd1;
    localparam logic [1:0] S_SRT = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [IDX_W-1:0]        r_cyc, n_cyc;
    logic [IDX_W-1:0]        r_pass, n_pass;
    logic                    r_have, n_have;
    logic signed [SUM_W-1:0] r_bsum, n_bsum;
    logic [IDX_W-1:0]        r_bidx, n_bidx;
    logic [IDX_W-1:0]        r_mark, n_mark;
    logic signed [SUM_W-1:0] r_s0, n_s0;
    logic [SUM_W-1:0]        r_gap, n_gap;
    logic [FND_W-1:0]        r_found, n_found;
    logic signed [SUM_W-1:0] r_thr;
    logic                    r_ovalid, n_ovalid;
    logic [IDX_W-1:0]        r_oidx, n_oidx;
    logic                    r_olast, n_olast;

    t_cell                   cells [LINES];
    t_cell                   feed;
    t_cell                   tail;
    logic                    shift, load, s_acc;
    logic                    excl, better, end_pass;
    logic signed [SUM_W:0]   wide;
    logic [IDX_W:0]          rank_p1;

    // ring of cells; cell 0 takes the modified tail
    for (genvar g = 0; g < LINES; g++) begin : g_ring
        lsrs_cell u_cell (
            .i_clk     (i_clk),
            .i_shift   (shift),
            .i_load    (load),
            .i_load_idx(IDX_W'(LINES - 1 - g)),
            .i_prev    ((g == 0) ? feed : cells[(g == 0) ? 0 : g - 1]),
            .o_data    (cells[g])
        );
    end

    assign tail       = cells[LINES-1];
    assign o_s_tready = (r_state == S_ACC);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign end_pass   = (r_cyc == IDX_W'(LINES - 1));
    assign rank_p1    = {1'b0, r_pass} + 1'b1;

    // saturating add at the head of the ring
    always_comb begin
        wide = {tail.sum[SUM_W-1], tail.sum} + {{(SUM_W+1-SMP_W){i_s_tdata[SMP_W-1]}}, i_s_tdata};
    end

    // picked flags count only after the first scan of a phase
    assign excl   = (r_pass != '0) && (tail.picked || (tail.idx == r_mark));
    assign better = !excl && (!r_have || (tail.sum > r_bsum) ||
                    ((tail.sum == r_bsum) && (tail.idx > r_bidx)));

    always_comb begin
        feed = tail;
        if (r_state == S_ACC) begin
            if (wide[SUM_W] != wide[SUM_W-1]) begin
                feed.sum = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                feed.sum = wide[SUM_W-1:0];
            end
        end else begin
            feed.picked = excl;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cyc    = r_cyc;
        n_pass   = r_pass;
        n_have   = r_have;
        n_bsum   = r_bsum;
        n_bidx   = r_bidx;
        n_mark   = r_mark;
        n_s0     = r_s0;
        n_gap    = r_gap;
        n_found  = r_found;
        n_ovalid = r_ovalid;
        n_oidx   = r_oidx;
        n_olast  = r_olast;
        shift    = 1'b0;
        load     = 1'b0;
        unique case (r_state)
            S_ACC: begin
                shift = s_acc;
                if (s_acc && i_s_tlast) begin
                    n_state = S_PRE;
                    n_cyc   = '0;
                    n_pass  = '0;
                    n_have  = 1'b0;
                    n_found = '0;
                end
            end
            S_PRE, S_SRT: begin
                shift = 1'b1;
                if (better) begin
                    n_have = 1'b1;
                    n_bsum = tail.sum;
                    n_bidx = tail.idx;
                end
                n_cyc = end_pass ? '0 : r_cyc + 1'b1;
                if (end_pass) begin
                    n_have = 1'b0;
                    n_mark = n_bidx;
                    if (r_state == S_PRE) begin
                        if (r_pass == '0) n_s0 = n_bsum;
                        if (r_pass == IDX_W'(1)) n_gap = r_s0 - n_bsum;
                        if ((int'(r_pass) < CHECKED) && (n_bsum >= r_thr)) begin
                            n_found = (rank_p1 > (IDX_W+1)'(7)) ? FND_W'(7) : rank_p1[FND_W-1:0];
                        end
                        if (int'(r_pass) == PRE_PASSES - 1) begin
                            n_state = S_SRT;
                            n_pass  = '0;
                        end else begin
                            n_pass = r_pass + 1'b1;
                        end
                    end else begin
                        n_state  = S_OUT;
                        n_ovalid = 1'b1;
                        n_oidx   = n_bidx;
                        n_olast  = (r_pass == IDX_W'(LINES - 1));
                    end
                end
            end
            S_OUT: begin
                if (i_m_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_state = S_ACC;
                        load    = 1'b1;
                    end else begin
                        n_state = S_SRT;
                        n_pass  = r_pass + 1'b1;
                    end
                end
            end
            default: n_state = S_ACC;
        endcase
        if (!i_rst_n) load = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_ACC;
            r_cyc    <= '0;
            r_pass   <= '0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
            r_thr    <= '0;
        end else begin
            r_state  <= n_state;
            r_cyc    <= n_cyc;
            r_pass   <= n_pass;
            r_have   <= n_have;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bsum  <= n_bsum;
        r_bidx  <= n_bidx;
        r_mark  <= n_mark;
        r_s0    <= n_s0;
        r_gap   <= n_gap;
        r_found <= n_found;
        r_oidx  <= n_oidx;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_olast;
    assign o_m_tdata  = {7'b0, r_found, r_gap, r_oidx};

`include "line_sum_rank_sort_assert.svh"
    `LSRS_ASSERT(a_out_state, !r_ovalid || (r_state == S_OUT), "result valid outside output state")
    `LSRS_ASSERT(a_idle_cyc, (r_state != S_ACC) || (r_cyc == '0), "scan counter not idle")
    `LSRS_ASSERT_NEXT(a_last_back, o_m_tvalid && i_m_tready && o_m_tlast, o_s_tready, "no return to accumulate")
endmodule
